// ===== src/tkst_pkg.sv =====
package tkst_pkg;

    // Fixed field widths of the item and register formats.
    localparam int TICKS_W   = 64;
    localparam int LIMIT_W   = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

    // Operation carried by each input item.
    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_DUMP = 1'b1
    } t_op;

endpackage

// ===== src/tkst_in_if.sv =====
interface tkst_in_if #(
    parameter int TAG_WIDTH = 16
);
    import tkst_pkg::*;

    logic                        valid;
    logic                        ready;
    t_op                         op;
    logic signed [TICKS_W-1:0]   ticks;
    logic        [TAG_WIDTH-1:0] tag;
    logic                        force_req;

    modport source (output valid, op, ticks, tag, force_req, input ready);
    modport sink   (input valid, op, ticks, tag, force_req, output ready);
endinterface

// ===== src/tkst_out_if.sv =====
interface tkst_out_if #(
    parameter int TAG_WIDTH = 16
);
    import tkst_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic                        entry_valid;
    logic signed [TICKS_W-1:0]   out_ticks;
    logic        [TAG_WIDTH-1:0] out_tag;
    logic                        last;

    modport source (output valid, accepted, entry_valid, out_ticks, out_tag, last,
                    input ready);
    modport sink   (input valid, accepted, entry_valid, out_ticks, out_tag, last,
                    output ready);
endinterface

// ===== src/tkst_cfg_if.sv =====
interface tkst_cfg_if;
    import tkst_pkg::*;

    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] entry_limit;

    modport source (output valid, entry_limit, input ready);
    modport sink   (input valid, entry_limit, output ready);
endinterface

// ===== src/top_k_sorted_tracker_top.sv =====
// Top-k sorted tracker.
// Keeps the entries with the largest signed tick counts, in descending order,
// each with a tag. Input items arrive on i_in (valid/ready): an add offers one
// entry, a dump reads out every held entry in order and empties the store.
// Results leave on o_out (valid/ready); the final result of an item has last set.
// The entry limit is written on i_cfg, which is always ready; write it only
// while the block is idle. After reset the store is empty and the limit is 16.
// An add walks the store from its tail, one entry per cycle through the
// comparators and the one-read, one-write entry memory. A dump reads each
// entry from memory and then loads it into the output register. An empty dump
// gives one result without an entry. With force_req, an add to a full store
// replaces the least entry even when the new entry is smaller.
// i_in is ready only between items. Finished results sit in an output register,
// so the next item can be taken while the previous result waits; when o_out
// stalls, the sequencer holds until the output register frees up.
module top_k_sorted_tracker_top #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkst_cfg_if.sink    i_cfg,
    tkst_in_if.sink     i_in,
    tkst_out_if.source  o_out
);
    import tkst_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    logic [LIMIT_W-1:0]   r_limit;
    logic [LW-1:0]        limit_ext;
    logic [CW-1:0]        limit_eff;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [TICKS_W-1:0]   wr_key;
    logic [TAG_WIDTH-1:0] wr_tag;
    logic [AW-1:0]        rd_addr;
    logic [TICKS_W-1:0]   rd_key;
    logic [TAG_WIDTH-1:0] rd_tag;

    // Limit register, written whenever the configuration channel offers data.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.entry_limit;
        end
    end

    // A limit of zero acts as one, a limit above the store depth as the depth.
    always_comb begin
        limit_ext = LW'(r_limit);
        if (limit_ext == '0) begin
            limit_ext = LW'(1);
        end else if (limit_ext > LW'(DEPTH)) begin
            limit_ext = LW'(DEPTH);
        end
        limit_eff = CW'(limit_ext);
    end

    tkst_seq #(
        .DEPTH     (DEPTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (i_in),
        .out_ch    (o_out),
        .i_limit   (limit_eff),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_key  (wr_key),
        .o_wr_tag  (wr_tag),
        .o_rd_addr (rd_addr),
        .i_rd_key  (rd_key),
        .i_rd_tag  (rd_tag)
    );

    tkst_store #(
        .DEPTH     (DEPTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_key  (wr_key),
        .i_wr_tag  (wr_tag),
        .i_rd_addr (rd_addr),
        .o_rd_key  (rd_key),
        .o_rd_tag  (rd_tag)
    );

endmodule

// ===== src/tkst_store.sv =====
module tkst_store #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [tkst_pkg::TICKS_W-1:0]  i_wr_key,
    input  logic [TAG_WIDTH-1:0]          i_wr_tag,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    output logic [tkst_pkg::TICKS_W-1:0]  o_rd_key,
    output logic [TAG_WIDTH-1:0]          o_rd_tag
);
    import tkst_pkg::*;

    logic [TICKS_W-1:0]   mem_key [DEPTH];
    logic [TAG_WIDTH-1:0] mem_tag [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_key[i_wr_addr] <= i_wr_key;
            mem_tag[i_wr_addr] <= i_wr_tag;
        end
        o_rd_key <= mem_key[i_rd_addr];
        o_rd_tag <= mem_tag[i_rd_addr];
    end

endmodule

// ===== src/tkst_seq.sv =====
module tkst_seq #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tkst_in_if.sink                       in_ch,
    tkst_out_if.source                    out_ch,
    input  logic [$clog2(DEPTH+1)-1:0]    i_limit,
    output logic                          o_wr_en,
    output logic [$clog2(DEPTH)-1:0]      o_wr_addr,
    output logic [tkst_pkg::TICKS_W-1:0]  o_wr_key,
    output logic [TAG_WIDTH-1:0]          o_wr_tag,
    output logic [$clog2(DEPTH)-1:0]      o_rd_addr,
    input  logic [tkst_pkg::TICKS_W-1:0]  i_rd_key,
    input  logic [TAG_WIDTH-1:0]          i_rd_tag
);
    import tkst_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEAST,
        S_WALK,
        S_PUT,
        S_RESP,
        S_DUMP_RD,
        S_DUMP_WT
    } t_state;

    t_state               r_state, n_state;
    logic [TICKS_W-1:0]   r_key, n_key;
    logic [TAG_WIDTH-1:0] r_tag, n_tag;
    logic                 r_force, n_force;
    logic [AW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_acc, n_acc;

    logic                 r_ov, n_ov;
    logic                 r_oacc, n_oacc;
    logic                 r_oev, n_oev;
    logic [TICKS_W-1:0]   r_oticks, n_oticks;
    logic [TAG_WIDTH-1:0] r_otag, n_otag;
    logic                 r_olast, n_olast;

    logic                 out_free;
    logic                 full;
    logic                 key_gt;
    logic                 least_gt;
    logic [AW-1:0]        cnt_last;

    // The compare units: new key against the entry just read, in both directions.
    assign key_gt   = $signed(r_key) > $signed(i_rd_key);
    assign least_gt = $signed(i_rd_key) > $signed(r_key);
    assign full     = r_cnt >= i_limit;
    assign cnt_last = AW'(r_cnt - CW'(1));
    assign out_free = !r_ov || out_ch.ready;

    assign in_ch.ready        = (r_state == S_IDLE);
    assign out_ch.valid       = r_ov;
    assign out_ch.accepted    = r_oacc;
    assign out_ch.entry_valid = r_oev;
    assign out_ch.out_ticks   = r_oticks;
    assign out_ch.out_tag     = r_otag;
    assign out_ch.last        = r_olast;

    // Sequencer: insertion walks from the tail toward the head, one entry a cycle.
    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_tag    = r_tag;
        n_force  = r_force;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_ov     = r_ov;
        n_oacc   = r_oacc;
        n_oev    = r_oev;
        n_oticks = r_oticks;
        n_otag   = r_otag;
        n_olast  = r_olast;

        o_wr_en   = 1'b0;
        o_wr_addr = AW'(r_idx + AW'(1));
        o_wr_key  = r_key;
        o_wr_tag  = r_tag;
        o_rd_addr = r_idx;

        if (r_ov && out_ch.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_ch.valid) begin
                    n_key   = in_ch.ticks;
                    n_tag   = in_ch.tag;
                    n_force = in_ch.force_req;
                    if (in_ch.op == OP_DUMP) begin
                        n_idx = '0;
                        if (r_cnt == '0) begin
                            n_acc   = 1'b0;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_DUMP_RD;
                        end
                    end else if (!full) begin
                        n_acc = 1'b1;
                        n_cnt = CW'(r_cnt + CW'(1));
                        if (r_cnt == '0) begin
                            n_idx   = '0;
                            n_state = S_PUT;
                        end else begin
                            o_rd_addr = cnt_last;
                            n_idx     = cnt_last;
                            n_state   = S_WALK;
                        end
                    end else begin
                        // Store full: first look at the least entry.
                        o_rd_addr = cnt_last;
                        n_idx     = cnt_last;
                        n_state   = S_LEAST;
                    end
                end
            end
            S_LEAST: begin
                if (!least_gt) begin
                    // The least is dropped and the new entry inserted.
                    n_acc = 1'b1;
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        o_rd_addr = AW'(r_idx - AW'(1));
                        n_idx     = AW'(r_idx - AW'(1));
                        n_state   = S_WALK;
                    end
                end else if (r_force) begin
                    n_acc   = 1'b1;
                    n_state = S_PUT;
                end else begin
                    n_acc   = 1'b0;
                    n_state = S_RESP;
                end
            end
            S_WALK: begin
                o_wr_en = 1'b1;
                if (key_gt) begin
                    // Shift the smaller entry one place toward the tail.
                    o_wr_key = i_rd_key;
                    o_wr_tag = i_rd_tag;
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        o_rd_addr = AW'(r_idx - AW'(1));
                        n_idx     = AW'(r_idx - AW'(1));
                    end
                end else begin
                    n_state = S_RESP;
                end
            end
            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_oacc   = r_acc;
                    n_oev    = 1'b0;
                    n_oticks = '0;
                    n_otag   = '0;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                n_state = S_DUMP_WT;
            end
            S_DUMP_WT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_oacc   = 1'b0;
                    n_oev    = 1'b1;
                    n_oticks = i_rd_key;
                    n_otag   = i_rd_tag;
                    n_olast  = (r_idx == cnt_last);
                    if (r_idx == cnt_last) begin
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = AW'(r_idx + AW'(1));
                        n_state = S_DUMP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, counters and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
        r_key    <= n_key;
        r_tag    <= n_tag;
        r_force  <= n_force;
        r_idx    <= n_idx;
        r_acc    <= n_acc;
        r_oacc   <= n_oacc;
        r_oev    <= n_oev;
        r_oticks <= n_oticks;
        r_otag   <= n_otag;
        r_olast  <= n_olast;
    end

endmodule
